// ----- rtl/s2dec_pkg.sv -----
`default_nettype none

package s2dec_pkg;

   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 7;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int SHIFT_W  = $clog2(VALUE_W);
   localparam int DCNT_W   = $clog2(DIGITS + 1);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

   typedef enum logic {
      EMIT_IDLE,
      EMIT_RUN
   } emit_state_type;

   // status and result of the binary to BCD converter
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [BCD_W-1:0] bcd;
   } conv_type;

endpackage

`default_nettype wire

// ----- rtl/s2dec_dabble.sv -----
`default_nettype none

module s2dec_dabble (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [s2dec_pkg::VALUE_W-1:0]   magnitude,
   output s2dec_pkg::conv_type                  conv
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [s2dec_pkg::SHIFT_W-1:0] cnt_ff, cnt_in;
   logic [s2dec_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [s2dec_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [s2dec_pkg::BCD_W-1:0]   adj;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < s2dec_pkg::DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = magnitude;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[s2dec_pkg::BCD_W-2:0], bin_ff[s2dec_pkg::VALUE_W-1]};
         bin_in = {bin_ff[s2dec_pkg::VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == s2dec_pkg::SHIFT_W'(s2dec_pkg::VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign conv.busy = busy_ff;
   assign conv.done = done_ff;
   assign conv.bcd  = bcd_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("converter done held for more than one cycle");
`endif

endmodule

`default_nettype wire

// ----- rtl/s2dec_emit.sv -----
`default_nettype none

module s2dec_emit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire s2dec_pkg::conv_type            conv,
   input  wire logic                           neg,
   output logic                                busy,
   output logic                                strobe,
   output logic [s2dec_pkg::CHAR_W-1:0]        character,
   output logic                                last
);

   s2dec_pkg::emit_state_type    state_ff, state_in;
   logic [s2dec_pkg::BCD_W-1:0]  digits_ff, digits_in;
   logic [s2dec_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                         sig_ff, sig_in;
   logic                         strobe_ff, strobe_in;
   logic                         last_ff, last_in;
   logic [s2dec_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [3:0]                   top;

   assign top = digits_ff[s2dec_pkg::BCD_W-1 -: 4];

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      cnt_in    = cnt_ff;
      sig_in    = sig_ff;
      strobe_in = 1'b0;
      last_in   = last_ff;
      char_in   = char_ff;
      case (state_ff)
         s2dec_pkg::EMIT_IDLE: begin
            if (conv.done) begin
               state_in  = s2dec_pkg::EMIT_RUN;
               digits_in = conv.bcd;
               cnt_in    = s2dec_pkg::DCNT_W'(s2dec_pkg::DIGITS);
               sig_in    = 1'b0;
               strobe_in = neg;
               char_in   = s2dec_pkg::CHAR_MINUS;
               last_in   = 1'b0;
            end
         end
         s2dec_pkg::EMIT_RUN: begin
            digits_in = {digits_ff[s2dec_pkg::BCD_W-5:0], 4'd0};
            cnt_in    = cnt_ff - 1'b1;
            // leading zeros drop out, but the units digit always goes
            if (sig_ff || top != 4'd0 || cnt_ff == s2dec_pkg::DCNT_W'(1)) begin
               sig_in    = 1'b1;
               strobe_in = 1'b1;
               char_in   = s2dec_pkg::CHAR_ZERO + {3'b000, top};
               last_in   = (cnt_ff == s2dec_pkg::DCNT_W'(1));
               if (cnt_ff == s2dec_pkg::DCNT_W'(1)) begin
                  state_in = s2dec_pkg::EMIT_IDLE;
               end
            end
         end
         default: begin
            state_in = s2dec_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= s2dec_pkg::EMIT_IDLE;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
         sig_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
         sig_ff    <= sig_in;
      end
      digits_ff <= digits_in;
      last_ff   <= last_in;
      char_ff   <= char_in;
   end

   assign busy      = (state_ff == s2dec_pkg::EMIT_RUN);
   assign strobe    = strobe_ff;
   assign character = char_ff;
   assign last      = last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && char_ff == s2dec_pkg::CHAR_MINUS) |-> !last_ff)
      else $error("minus sign marked as final character");
`endif

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii.sv -----
`default_nettype none

// Converts a signed 32-bit integer to its decimal text, one ASCII character
// per beat, most significant first: a '-' for negative values, then the digits
// with no leading zeros ('0' alone for zero); rsp_last marks the final beat.
// A value is taken when start is high and busy low. Beats appear on
// rsp_character/rsp_last for exactly one cycle with rsp_strobe high; the
// receiver cannot stall them, so it must take every strobed beat. Each value
// passes from start through the bit-serial binary to BCD shifter (one
// magnitude bit per cycle), then the digit emitter, which walks all ten BCD
// digits one per cycle (leading zeros are skipped silently; the sign goes out
// as it loads).

module signed_int_to_decimal_ascii (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic signed [s2dec_pkg::VALUE_W-1:0] req_value,
   output logic                                  rsp_strobe,
   output logic [s2dec_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                  rsp_last
);

   logic                          accept;
   logic                          neg_ff, neg_in;
   logic [s2dec_pkg::VALUE_W-1:0] magnitude;
   logic                          emit_busy;
   s2dec_pkg::conv_type           conv;

   assign accept = start && !busy;

   // unsigned negation, so the most negative value gives 2147483648
   assign magnitude = req_value[s2dec_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
   assign neg_in    = accept ? req_value[s2dec_pkg::VALUE_W-1] : neg_ff;

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   s2dec_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .magnitude (magnitude),
      .conv      (conv)
   );

   s2dec_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .conv      (conv),
      .neg       (neg_ff),
      .busy      (emit_busy),
      .strobe    (rsp_strobe),
      .character (rsp_character),
      .last      (rsp_last)
   );

   assign busy = conv.busy || conv.done || emit_busy;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("busy not raised after accepting a value");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("beat emitted after final character");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_character == s2dec_pkg::CHAR_MINUS ||
                      (rsp_character >= s2dec_pkg::CHAR_ZERO &&
                       rsp_character <= s2dec_pkg::CHAR_NINE)))
      else $error("character outside sign and digit set");
   // the final beat leaves the register after the emitter has gone idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy || rsp_last))
      else $error("beat emitted while idle");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [s2dec_pkg::CHAR_W-1:0] character;
      logic                         last;
   } char_beat_type;

   // holds the characters still owed by the block, oldest first
   class text_tracker;
      char_beat_type pending_chars[$];
      int            mismatches = 0;

      function void note_value(logic signed [s2dec_pkg::VALUE_W-1:0] value);
         logic [s2dec_pkg::VALUE_W-1:0] mag;
         logic [3:0]                    dig[s2dec_pkg::DIGITS];
         int                            nd;
         char_beat_type                 beat;
         nd = 0;
         // unsigned negate: the most negative value gives 2147483648
         mag = value[s2dec_pkg::VALUE_W-1] ? (32'd0 - value) : value;
         do begin
            dig[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
         end while (mag != 0 && nd < s2dec_pkg::DIGITS);
         if (value[s2dec_pkg::VALUE_W-1]) begin
            beat.character = s2dec_pkg::CHAR_MINUS;
            beat.last      = 1'b0;
            pending_chars.push_back(beat);
         end
         for (int i = nd - 1; i >= 0; i--) begin
            beat.character = s2dec_pkg::CHAR_ZERO + s2dec_pkg::CHAR_W'(dig[i]);
            beat.last      = (i == 0);
            pending_chars.push_back(beat);
         end
      endfunction

      function void check_char(logic [s2dec_pkg::CHAR_W-1:0] character, logic last);
         char_beat_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected beat, character %0d last %0b", $realtime,
                     character, last);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (character !== want.character) begin
               $display("%0t: character expected %0d actual %0d", $realtime,
                        want.character, character);
               mismatches++;
            end
            if (last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $realtime,
                        want.last, last);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic signed [s2dec_pkg::VALUE_W-1:0] req_value = '0;
   logic                                 busy;
   logic                                 rsp_strobe;
   logic [s2dec_pkg::CHAR_W-1:0]         rsp_character;
   logic                                 rsp_last;

   text_tracker board = new();

   signed_int_to_decimal_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_value(req_value);
         if (rsp_strobe) board.check_char(rsp_character, rsp_last);
      end
   end

   // start stays high across back-to-back values within a burst
   task automatic send_value(logic signed [s2dec_pkg::VALUE_W-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int cycles);
      start     <= 1'b0;
      req_value <= $urandom;
      repeat (cycles) begin
         @(posedge clock);
         req_value <= $urandom;
      end
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(1, 70);
   endfunction

   // mostly values of a chosen digit count, the rest raw words
   function automatic logic signed [s2dec_pkg::VALUE_W-1:0] pick_value();
      int unsigned                   p10;
      int unsigned                   lo;
      int unsigned                   hi;
      int                            n;
      logic [s2dec_pkg::VALUE_W-1:0] mag;
      if ($urandom_range(0, 9) < 3) return $urandom;
      n   = $urandom_range(1, s2dec_pkg::DIGITS);
      p10 = 1;
      for (int k = 0; k < n - 1; k++) p10 = p10 * 10;
      lo  = (n == 1) ? 0 : p10;
      hi  = (n == s2dec_pkg::DIGITS) ? 32'h7FFF_FFFF : p10 * 10 - 1;
      mag = $urandom_range(hi, lo);
      if ($urandom_range(0, 1)) begin
         if (n == s2dec_pkg::DIGITS && $urandom_range(0, 7) == 0) mag = 32'h8000_0000;
         return 32'd0 - mag;
      end
      return mag;
   endfunction

   logic signed [s2dec_pkg::VALUE_W-1:0] corner_values[$] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
      999999999, -999999999, 1000000000, -1000000000,
      32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
   };

   initial begin
      int remaining;
      int burst;
      int gap;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
         gap = pick_gap();
         if (gap > 0) idle_for(gap);
      end

      remaining = 270;
      while (remaining > 0) begin
         burst = $urandom_range(1, 8);
         for (int j = 0; j < burst && remaining > 0; j++) begin
            send_value(pick_value());
            remaining--;
         end
         gap = pick_gap();
         if (gap > 0) idle_for(gap);
      end
      start <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $realtime);
      $display("tb: done, errors");
      $finish;
   end

endmodule
